### design/iosd_pkg.sv
package iosd_pkg;

  typedef enum logic [1:0] {
    OP_BUS  = 2'd0,
    OP_LOAD = 2'd1,
    OP_KEY  = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  localparam logic [15:0] ADDR_KBD      = 16'hC000;
  localparam logic [15:0] ADDR_KSTROBE  = 16'hC010;
  localparam logic [15:0] ADDR_TXTCLR   = 16'hC050;
  localparam logic [15:0] ADDR_TXTSET   = 16'hC051;
  localparam logic [15:0] ADDR_MIXCLR   = 16'hC052;
  localparam logic [15:0] ADDR_MIXSET   = 16'hC053;
  localparam logic [15:0] ADDR_PAGE1    = 16'hC054;
  localparam logic [15:0] ADDR_PAGE2    = 16'hC055;
  localparam logic [15:0] ADDR_LORES    = 16'hC056;
  localparam logic [15:0] ADDR_HIRES    = 16'hC057;
  localparam logic [15:0] ADDR_BUTTON0  = 16'hC061;
  localparam logic [15:0] ADDR_BUTTON1  = 16'hC062;
  localparam logic [15:0] ADDR_ROMOFF   = 16'hCFFF;
  localparam logic [15:0] ADDR_MOTOROFF = 16'hC0E8;
  localparam logic [15:0] ADDR_MOTORON  = 16'hC0E9;
  localparam logic [15:0] ADDR_DRIVE0   = 16'hC0EA;
  localparam logic [15:0] ADDR_DRIVE1   = 16'hC0EB;
  localparam logic [15:0] ADDR_SHIFT    = 16'hC0EC;
  localparam logic [15:0] ADDR_LOAD     = 16'hC0ED;
  localparam logic [15:0] ADDR_READMODE = 16'hC0EE;
  localparam logic [15:0] ADDR_WRITEMODE = 16'hC0EF;
  localparam logic [11:0] ADDR_LC_PAGE  = 12'hC08;
  localparam logic [12:0] ADDR_PHASE    = 13'h181C;

  typedef struct packed {
    logic       start;
    logic       mem_write;
    logic       capture;
  } iosd_cmd_t;

endpackage

### design/iosd_word_if.sv
interface iosd_word_if #(parameter int unsigned WIDTH = 2);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/iosd_in_if.sv
interface iosd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] bus_address;
  logic [7:0]  write_data;
  logic        is_write;
  logic [7:0]  bus_noise;
  logic        load_drive;
  logic [17:0] image_index;
  modport source (output valid, output op, output bus_address, output write_data,
                  output is_write, output bus_noise, output load_drive,
                  output image_index, input ready);
  modport sink (input valid, input op, input bus_address, input write_data,
                input is_write, input bus_noise, input load_drive,
                input image_index, output ready);
endinterface

### design/iosd_out_if.sv
interface iosd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       text_view;
  logic       mixed_mode;
  logic       hires_view;
  logic       page_two;
  logic       lc_bank_two;
  logic       lc_read_ram;
  logic       lc_write_ram;
  logic       motor_on;
  logic       drive_select;
  logic [6:0] head_track;
  modport source (output valid, output read_data, output text_view, output mixed_mode,
                  output hires_view, output page_two, output lc_bank_two,
                  output lc_read_ram, output lc_write_ram, output motor_on,
                  output drive_select, output head_track, input ready);
  modport sink (input valid, input read_data, input text_view, input mixed_mode,
                input hires_view, input page_two, input lc_bank_two,
                input lc_read_ram, input lc_write_ram, input motor_on,
                input drive_select, input head_track, output ready);
endinterface

### design/iosd_ram.sv
module iosd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/iosd_ctrl.sv
module iosd_ctrl
  import iosd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  output iosd_cmd_t cmd
);
  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DONE} state_t;
  state_t state;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign cmd.start     = (state == S_IDLE) && in_valid;
  assign cmd.mem_write = 1'b0;
  assign cmd.capture   = (state == S_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_EXEC;
        S_EXEC: state <= S_DONE;
        S_DONE: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### design/iosd_datapath.sv
module iosd_datapath
  import iosd_pkg::*;
#(
  parameter int unsigned TRACK_NIBBLES  = 6656,
  parameter int unsigned TRACKS         = 35,
  parameter int unsigned MAX_HALF_TRACK = 140
) (
  input  logic        clk,
  input  logic        rst,
  input  iosd_cmd_t   cmd,
  input  logic [1:0]  wp,
  input  logic        wp_we,
  input  logic [1:0]  op,
  input  logic [15:0] bus_address,
  input  logic [7:0]  write_data,
  input  logic        is_write,
  input  logic [7:0]  bus_noise,
  input  logic        load_drive,
  input  logic [17:0] image_index,
  output logic [7:0]  read_data,
  output logic [3:0]  vflags,
  output logic [2:0]  lflags,
  output logic        motor_on,
  output logic        drive_select,
  output logic [6:0]  head_track
);
  localparam int unsigned IMAGE = TRACKS * TRACK_NIBBLES;
  localparam int unsigned DEPTH = 2 * IMAGE;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(TRACK_NIBBLES);
  localparam int unsigned IW = $clog2(IMAGE + 1);

  logic [1:0] wprot;
  logic [7:0] key_latch, data_latch;
  logic [3:0] video, lc;
  logic sel;
  logic [1:0] motor, wmode;
  logic [6:0] track [2];
  logic [NW-1:0] npos [2];
  logic [7:0] htp [2];
  logic [3:0] pnow [2], pprev [2], pprev2 [2];
  logic [1:0] pidx [2], pidxp [2];

  logic [1:0]    r_op;
  logic [15:0]   r_addr;
  logic [7:0]    r_wd, r_noise;
  logic          r_wr;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;

  logic [6:0]  t_clamp;
  logic [AW-1:0] shift_addr;

  always_comb begin
    t_clamp = (track[sel] > 7'(TRACKS - 1)) ? 7'(TRACKS - 1) : track[sel];
    shift_addr = (sel ? AW'(IMAGE) : '0) + AW'(t_clamp) * AW'(TRACK_NIBBLES)
               + AW'(npos[sel]);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_addr = shift_addr;
    mem_wdata = data_latch;
    if (cmd.start && (op == OP_LOAD)) begin
      mem_we = ({1'b0, image_index} < (IW + 1)'(IMAGE));
      mem_addr = (load_drive ? AW'(IMAGE) : '0) + AW'(image_index);
      mem_wdata = write_data;
    end else if (cmd.start && (op == OP_BUS) && (bus_address == ADDR_SHIFT)
                 && wmode[sel]) begin
      mem_we = 1'b1;
    end
  end

  iosd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(mem_we | cmd.mem_write), .waddr(mem_addr), .wdata(mem_wdata),
    .raddr(mem_addr), .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r_op <= op;
      r_addr <= bus_address;
      r_wd <= write_data;
      r_wr <= is_write;
      r_noise <= bus_noise;
    end
  end

  logic [1:0] ph, pi, pb, b1, b3;
  logic [3:0] np2, np;
  always_comb begin
    ph = r_addr[2:1];
    pi = pidx[sel];
    pb = pidxp[sel];
    np2 = (pprev2[sel] & ~(4'b1 << pb)) | (pprev[sel] & (4'b1 << pb));
    np  = (pprev[sel] & ~(4'b1 << pi)) | (pnow[sel] & (4'b1 << pi));
    b1 = ph + 2'd1;
    b3 = ph + 2'd3;
  end

  always_ff @(posedge clk) begin
    logic [7:0] h;
    logic [3:0] f;
    if (rst) begin
      wprot <= '0; key_latch <= '0; data_latch <= '0; video <= 4'b0001; lc <= '0;
      sel <= 1'b0; motor <= '0; wmode <= '0; read_data <= '0;
      for (int i = 0; i < 2; i++) begin
        track[i] <= '0; npos[i] <= '0; htp[i] <= '0; pnow[i] <= '0;
        pprev[i] <= '0; pprev2[i] <= '0; pidx[i] <= '0; pidxp[i] <= '0;
      end
    end else begin
      if (wp_we) wprot <= wp;
      if (cmd.capture) begin
        read_data <= 8'h00;
        if (r_op == OP_KEY) key_latch <= r_wd;
        if (r_op == OP_BUS) begin
          read_data <= r_noise;
          if (r_addr[15:4] == ADDR_LC_PAGE) begin
            f = r_addr[3] ? 4'b0000 : 4'b0001;
            unique case (r_addr[1:0])
              2'd0: f[1] = 1'b1;
              2'd1: begin
                f[2] = lc[2] | lc[3];
                f[3] = ~r_wr;
              end
              2'd2: ;
              default: begin
                f[1] = 1'b1;
                f[2] = lc[2] | lc[3];
                f[3] = ~r_wr;
              end
            endcase
            lc <= f;
          end else if (r_addr[15:3] == ADDR_PHASE) begin
            pprev2[sel] <= np2;
            pprev[sel] <= np;
            pidxp[sel] <= pi;
            pidx[sel] <= ph;
            if (!r_addr[0]) begin
              pnow[sel] <= pnow[sel] & ~(4'b1 << ph);
            end else begin
              h = htp[sel];
              if (np2[b1] && h > 8'd0) h = h - 8'd1;
              if (np2[b3]) h = (h < 8'(MAX_HALF_TRACK)) ? h + 8'd1 : 8'(MAX_HALF_TRACK);
              htp[sel] <= h;
              pnow[sel] <= pnow[sel] | (4'b1 << ph);
              track[sel] <= 7'((9'(h) + 9'd1) >> 1);
            end
          end else begin
            unique case (r_addr)
              ADDR_KBD: read_data <= key_latch;
              ADDR_KSTROBE: begin
                key_latch[7] <= 1'b0;
                read_data <= {1'b0, key_latch[6:0]};
              end
              ADDR_TXTCLR: video[0] <= 1'b0;
              ADDR_TXTSET: video[0] <= 1'b1;
              ADDR_MIXCLR: video[1] <= 1'b0;
              ADDR_MIXSET: video[1] <= 1'b1;
              ADDR_PAGE1: video[3] <= 1'b0;
              ADDR_PAGE2: video[3] <= 1'b1;
              ADDR_LORES: video[2] <= 1'b0;
              ADDR_HIRES: video[2] <= 1'b1;
              ADDR_BUTTON0, ADDR_BUTTON1: read_data <= 8'h00;
              ADDR_ROMOFF, ADDR_MOTOROFF: motor[sel] <= 1'b0;
              ADDR_MOTORON: motor[sel] <= 1'b1;
              ADDR_DRIVE0: begin
                motor[0] <= motor[0] | motor[1]; motor[1] <= 1'b0; sel <= 1'b0;
              end
              ADDR_DRIVE1: begin
                motor[1] <= motor[0] | motor[1]; motor[0] <= 1'b0; sel <= 1'b1;
              end
              ADDR_SHIFT: begin
                if (!wmode[sel]) begin
                  data_latch <= mem_rdata;
                  read_data <= mem_rdata;
                end else begin
                  read_data <= data_latch;
                end
                npos[sel] <= (npos[sel] == NW'(TRACK_NIBBLES - 1)) ? '0 : npos[sel] + 1'b1;
              end
              ADDR_LOAD: data_latch <= r_wd;
              ADDR_READMODE: begin
                wmode[sel] <= 1'b0;
                read_data <= {wprot[sel], 7'd0};
              end
              ADDR_WRITEMODE: wmode[sel] <= 1'b1;
              default: ;
            endcase
          end
        end
      end
    end
  end

  assign vflags = video;
  assign lflags = lc[2:0];
  assign motor_on = motor[sel];
  assign drive_select = sel;
  assign head_track = track[sel];
endmodule

### design/io_soft_switch_disk_controller.sv
// Each input word passes through the accept, execute and present states before its
// result word; a new word is taken only after the result word is accepted. The disk store
// read port has registered read data, which is consumed in the execute state.
// Reset: synchronous, active high; selects the text display, clears every other
// switch, the drive state and the write-protect register. The disk store is kept.
module io_soft_switch_disk_controller
  import iosd_pkg::*;
#(
  parameter int unsigned TRACK_NIBBLES  = 6656,
  parameter int unsigned TRACKS         = 35,
  parameter int unsigned MAX_HALF_TRACK = 140
) (
  input logic clk,
  input logic rst,
  iosd_in_if.sink     in_ch,
  iosd_out_if.source  out_ch,
  iosd_word_if.sink   cfg
);
  iosd_cmd_t  cmd;
  logic [3:0] vflags;
  logic [2:0] lflags;

  assign cfg.ready = 1'b1;

  iosd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid), .cmd(cmd)
  );

  iosd_datapath #(
    .TRACK_NIBBLES(TRACK_NIBBLES), .TRACKS(TRACKS), .MAX_HALF_TRACK(MAX_HALF_TRACK)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .wp(cfg.data), .wp_we(cfg.valid),
    .op(in_ch.op), .bus_address(in_ch.bus_address), .write_data(in_ch.write_data),
    .is_write(in_ch.is_write), .bus_noise(in_ch.bus_noise),
    .load_drive(in_ch.load_drive), .image_index(in_ch.image_index),
    .read_data(out_ch.read_data), .vflags(vflags), .lflags(lflags),
    .motor_on(out_ch.motor_on), .drive_select(out_ch.drive_select),
    .head_track(out_ch.head_track)
  );

  assign out_ch.text_view    = vflags[0];
  assign out_ch.mixed_mode   = vflags[1];
  assign out_ch.hires_view   = vflags[2];
  assign out_ch.page_two     = vflags[3];
  assign out_ch.lc_bank_two  = lflags[0];
  assign out_ch.lc_read_ram  = lflags[1];
  assign out_ch.lc_write_ram = lflags[2];
endmodule

### tb/io_soft_switch_disk_controller_tb.sv
`timescale 1ns / 100ps

module io_soft_switch_disk_controller_tb;
  import iosd_pkg::*;

  localparam int TRACK_NIBBLES  = 6656;
  localparam int TRACKS         = 35;
  localparam int MAX_HALF_TRACK = 140;
  localparam int IMAGE_BYTES    = TRACKS * TRACK_NIBBLES;
  localparam int SETTLE         = 12;
  localparam int RANDOM_WORDS   = 1100;

  typedef struct packed {
    op_t         op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        wr;
    logic [7:0]  noise;
    logic        drive;
    logic [17:0] index;
  } bus_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       text_view;
    logic       mixed_mode;
    logic       hires_view;
    logic       page_two;
    logic       lc_bank_two;
    logic       lc_read_ram;
    logic       lc_write_ram;
    logic       motor_on;
    logic       drive_select;
    logic [6:0] head_track;
  } status_word_t;

  typedef struct packed {
    bus_word_t  word;
    logic       known;
    logic [7:0] read_data;
  } directed_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  iosd_in_if   in_ch ();
  iosd_out_if  out_ch ();
  iosd_word_if cfg ();

  io_soft_switch_disk_controller DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg    (cfg.sink)
  );

  always #1 clk = ~clk;

  // Controller model state
  logic [1:0]  wp;
  logic [7:0]  key_q;
  logic        txt, mix, hir, pg2;
  logic        lc_bank, lc_rd, lc_wr, lc_pre;
  logic [7:0]  latch;
  logic        sel;
  logic        motor [2];
  logic        wmode [2];
  logic [6:0]  trk [2];
  int          nib [2];
  int          half [2];
  logic [3:0]  ph_now [2];
  logic [3:0]  ph_prev [2];
  logic [3:0]  ph_prev2 [2];
  logic [1:0]  ph_idx [2];
  logic [1:0]  ph_idx_prev [2];
  logic [7:0]  image [int];

  status_word_t pending_status [$];
  bit  failed;
  bit  steady;
  int  words_checked, words_sent, loads_sent, deepest_half;

  function automatic int image_addr(logic d);
    int t;
    t = trk[d];
    if (t > TRACKS - 1) t = TRACKS - 1;
    return d * IMAGE_BYTES + t * TRACK_NIBBLES + nib[d] % TRACK_NIBBLES;
  endfunction

  function automatic void step_stepper(logic [2:0] low);
    logic       d;
    logic [1:0] ph, pi, pb;
    d  = sel;
    ph = low[2:1];
    pi = ph_idx[d];
    pb = ph_idx_prev[d];
    ph_prev2[d][pb]   = ph_prev[d][pb];
    ph_prev[d][pi]    = ph_now[d][pi];
    ph_idx_prev[d]    = pi;
    ph_idx[d]         = ph;
    if (!low[0]) begin
      ph_now[d][ph] = 1'b0;
      return;
    end
    if (ph_prev2[d][2'(ph + 2'd1)] && half[d] > 0) half[d]--;
    if (ph_prev2[d][2'(ph + 2'd3)] && half[d] < MAX_HALF_TRACK) half[d]++;
    ph_now[d][ph] = 1'b1;
    trk[d] = 7'((half[d] + 1) / 2);
    if (half[d] > deepest_half) deepest_half = half[d];
  endfunction

  function automatic void pick_drive(logic d);
    motor[d]  = motor[d] | motor[~d];
    motor[~d] = 1'b0;
    sel       = d;
  endfunction

  function automatic logic [7:0] decode_access(bus_word_t w);
    logic       d;
    logic [3:0] low;
    int         a;
    d = sel;
    if (w.addr[15:4] == ADDR_LC_PAGE) begin
      low = w.addr[3:0];
      lc_bank = !low[3];
      case (low[1:0])
        2'd0: begin
          lc_rd = 1'b1; lc_wr = 1'b0; lc_pre = 1'b0;
        end
        2'd1: begin
          lc_rd = 1'b0; lc_wr = lc_wr | lc_pre; lc_pre = !w.wr;
        end
        2'd2: begin
          lc_rd = 1'b0; lc_wr = 1'b0; lc_pre = 1'b0;
        end
        default: begin
          lc_rd = 1'b1; lc_wr = lc_wr | lc_pre; lc_pre = !w.wr;
        end
      endcase
      return w.noise;
    end
    if (w.addr[15:3] == ADDR_PHASE) begin
      step_stepper(w.addr[2:0]);
      return w.noise;
    end
    case (w.addr)
      ADDR_KBD:      return key_q;
      ADDR_KSTROBE: begin
        key_q[7] = 1'b0;
        return key_q;
      end
      ADDR_TXTCLR:   txt = 1'b0;
      ADDR_TXTSET:   txt = 1'b1;
      ADDR_MIXCLR:   mix = 1'b0;
      ADDR_MIXSET:   mix = 1'b1;
      ADDR_PAGE1:    pg2 = 1'b0;
      ADDR_PAGE2:    pg2 = 1'b1;
      ADDR_LORES:    hir = 1'b0;
      ADDR_HIRES:    hir = 1'b1;
      ADDR_BUTTON0,
      ADDR_BUTTON1:  return 8'h00;
      ADDR_ROMOFF,
      ADDR_MOTOROFF: motor[d] = 1'b0;
      ADDR_MOTORON:  motor[d] = 1'b1;
      ADDR_DRIVE0:   pick_drive(1'b0);
      ADDR_DRIVE1:   pick_drive(1'b1);
      ADDR_SHIFT: begin
        a = image_addr(d);
        if (wmode[d]) image[a] = latch;
        else latch = image[a];
        nib[d] = (nib[d] + 1) % TRACK_NIBBLES;
        return latch;
      end
      ADDR_LOAD:     latch = w.wdata;
      ADDR_READMODE: begin
        wmode[d] = 1'b0;
        return wp[d] ? 8'h80 : 8'h00;
      end
      ADDR_WRITEMODE: wmode[d] = 1'b1;
      default: ;
    endcase
    return w.noise;
  endfunction

  function automatic status_word_t apply_word(bus_word_t w);
    status_word_t s;
    s.read_data = 8'h00;
    case (w.op)
      OP_BUS:  s.read_data = decode_access(w);
      OP_LOAD: if (w.index < IMAGE_BYTES) image[w.drive * IMAGE_BYTES + w.index] = w.wdata;
      OP_KEY:  key_q = w.wdata;
      default: ;
    endcase
    s.text_view    = txt;
    s.mixed_mode   = mix;
    s.hires_view   = hir;
    s.page_two     = pg2;
    s.lc_bank_two  = lc_bank;
    s.lc_read_ram  = lc_rd;
    s.lc_write_ram = lc_wr;
    s.motor_on     = motor[sel];
    s.drive_select = sel;
    s.head_track   = trk[sel];
    return s;
  endfunction

  function automatic bus_word_t make_word(op_t op, logic [15:0] addr, logic [7:0] wdata);
    bus_word_t w;
    w.op    = op;
    w.addr  = addr;
    w.wdata = wdata;
    w.wr    = 1'($urandom);
    w.noise = 8'($urandom);
    w.drive = 1'($urandom);
    w.index = 18'($urandom);
    return w;
  endfunction

  task automatic drive_word(bus_word_t w, bit known, logic [7:0] known_rd);
    status_word_t s;
    if (!steady && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= w.op;
    in_ch.bus_address <= w.addr;
    in_ch.write_data  <= w.wdata;
    in_ch.is_write    <= w.wr;
    in_ch.bus_noise   <= w.noise;
    in_ch.load_drive  <= w.drive;
    in_ch.image_index <= w.index;
    s = apply_word(w);
    if (known) s.read_data = known_rd;
    pending_status.push_back(s);
    words_sent++;
    if (w.op == OP_LOAD) loads_sent++;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Load the byte under the head before any read shift that would find it empty.
  task automatic issue(bus_word_t w, bit known = 1'b0, logic [7:0] known_rd = 8'h00);
    bus_word_t fill;
    int        a;
    if (w.op == OP_BUS && w.addr == ADDR_SHIFT && !wmode[sel]) begin
      a = image_addr(sel);
      if (!image.exists(a)) begin
        fill       = make_word(OP_LOAD, 16'($urandom), 8'($urandom));
        fill.drive = sel;
        fill.index = 18'(a - sel * IMAGE_BYTES);
        drive_word(fill, 1'b0, 8'h00);
      end
    end
    drive_word(w, known, known_rd);
  endtask

  task automatic write_protect_set(logic [1:0] value);
    in_ch.valid <= 1'b0;
    wait (pending_status.size() == 0);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    wp = value;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic stepper_walk(int steps, bit outward);
    logic [1:0] p, q;
    p = 2'($urandom);
    for (int k = 0; k < steps; k++) begin
      q = outward ? 2'(p + 2'd1) : 2'(p - 2'd1);
      issue(make_word(OP_BUS, {ADDR_PHASE, q, 1'b1}, 8'($urandom)));
      issue(make_word(OP_BUS, {ADDR_PHASE, p, 1'b0}, 8'($urandom)));
      p = q;
    end
  endtask

  function automatic bus_word_t random_word();
    int          r;
    logic [15:0] switches [10];
    switches = '{ADDR_KBD, ADDR_KSTROBE, ADDR_TXTCLR, ADDR_TXTSET, ADDR_MIXCLR,
                 ADDR_MIXSET, ADDR_PAGE1, ADDR_PAGE2, ADDR_LORES, ADDR_HIRES};
    r = $urandom_range(99);
    if (r < 8) return make_word(OP_LOAD, 16'($urandom), 8'($urandom));
    if (r < 12) return make_word(OP_KEY, 16'($urandom), 8'($urandom));
    if (r < 14) return make_word(OP_NOP, 16'($urandom), 8'($urandom));
    if (r < 30) return make_word(OP_BUS, {ADDR_PHASE, 3'($urandom)}, 8'($urandom));
    if (r < 50) return make_word(OP_BUS, {ADDR_PHASE, 1'b1, 2'($urandom)}, 8'($urandom));
    if (r < 60) return make_word(OP_BUS, {ADDR_LC_PAGE, 4'($urandom)}, 8'($urandom));
    if (r < 75) return make_word(OP_BUS, switches[$urandom_range(9)], 8'($urandom));
    if (r < 80) return make_word(OP_BUS, 16'hC000 | 16'($urandom_range(8'h6F)),
                                 8'($urandom));
    if (r < 83) return make_word(OP_BUS, ADDR_ROMOFF, 8'($urandom));
    return make_word(OP_BUS, 16'($urandom), 8'($urandom));
  endfunction

  function automatic void check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $error("%s: expected %0h, got %0h", name, expected, actual);
      failed = 1'b1;
    end
  endfunction

  initial out_ch.ready = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || $urandom_range(99) >= 25;
    end
  end

  always @(posedge clk) begin
    status_word_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_status.size() == 0) begin
        $error("read_data: unexpected word %0h", out_ch.read_data);
        failed = 1'b1;
      end else begin
        e = pending_status.pop_front();
        words_checked++;
        check_field("read_data", e.read_data, out_ch.read_data);
        check_field("text_view", e.text_view, out_ch.text_view);
        check_field("mixed_mode", e.mixed_mode, out_ch.mixed_mode);
        check_field("hires_view", e.hires_view, out_ch.hires_view);
        check_field("page_two", e.page_two, out_ch.page_two);
        check_field("lc_bank_two", e.lc_bank_two, out_ch.lc_bank_two);
        check_field("lc_read_ram", e.lc_read_ram, out_ch.lc_read_ram);
        check_field("lc_write_ram", e.lc_write_ram, out_ch.lc_write_ram);
        check_field("motor_on", e.motor_on, out_ch.motor_on);
        check_field("drive_select", e.drive_select, out_ch.drive_select);
        check_field("head_track", e.head_track, out_ch.head_track);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("** io_soft_switch_disk_controller: FAILED **");
    $finish;
  end

  initial begin
    directed_t   directed [27];
    logic [1:0]  settings [4];
    int          sent;

    in_ch.valid = 1'b0;
    in_ch.op = OP_NOP;
    in_ch.bus_address = '0;
    in_ch.write_data = '0;
    in_ch.is_write = 1'b0;
    in_ch.bus_noise = '0;
    in_ch.load_drive = 1'b0;
    in_ch.image_index = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;

    wp = 2'd0; key_q = 8'h00; txt = 1'b1; mix = 1'b0; hir = 1'b0; pg2 = 1'b0;
    lc_bank = 1'b0; lc_rd = 1'b0; lc_wr = 1'b0; lc_pre = 1'b0;
    latch = 8'h00; sel = 1'b0;
    for (int d = 0; d < 2; d++) begin
      motor[d] = 1'b0; wmode[d] = 1'b0; trk[d] = '0; nib[d] = 0; half[d] = 0;
      ph_now[d] = '0; ph_prev[d] = '0; ph_prev2[d] = '0;
      ph_idx[d] = '0; ph_idx_prev[d] = '0;
    end
    failed = 1'b0; steady = 1'b0;
    words_checked = 0; words_sent = 0; loads_sent = 0; deepest_half = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed = '{
      '{'{OP_BUS,  ADDR_KBD,       8'h00, 1'b0, 8'h11, 1'b0, 18'd0},      1'b1, 8'h00},
      '{'{OP_KEY,  16'h0000,       8'hFF, 1'b1, 8'hFF, 1'b1, 18'h3FFFF},  1'b1, 8'h00},
      '{'{OP_BUS,  ADDR_KBD,       8'h00, 1'b0, 8'h00, 1'b0, 18'd0},      1'b1, 8'hFF},
      '{'{OP_BUS,  ADDR_KSTROBE,   8'hFF, 1'b1, 8'h00, 1'b0, 18'd0},      1'b1, 8'h7F},
      '{'{OP_BUS,  ADDR_TXTCLR,    8'h00, 1'b0, 8'h22, 1'b0, 18'd0},      1'b1, 8'h22},
      '{'{OP_BUS,  ADDR_MIXSET,    8'h00, 1'b1, 8'h33, 1'b0, 18'd0},      1'b1, 8'h33},
      '{'{OP_BUS,  ADDR_HIRES,     8'h00, 1'b0, 8'h44, 1'b0, 18'd0},      1'b1, 8'h44},
      '{'{OP_BUS,  ADDR_PAGE2,     8'h00, 1'b0, 8'h55, 1'b0, 18'd0},      1'b1, 8'h55},
      '{'{OP_BUS,  16'hC080,       8'h00, 1'b0, 8'h66, 1'b0, 18'd0},      1'b0, 8'h00},
      '{'{OP_BUS,  16'hC081,       8'h00, 1'b0, 8'h77, 1'b0, 18'd0},      1'b0, 8'h00},
      '{'{OP_BUS,  16'hC081,       8'h00, 1'b0, 8'h88, 1'b0, 18'd0},      1'b0, 8'h00},
      '{'{OP_BUS,  16'hC08B,       8'h00, 1'b1, 8'h99, 1'b0, 18'd0},      1'b0, 8'h00},
      '{'{OP_BUS,  16'hC08A,       8'h00, 1'b0, 8'hAA, 1'b0, 18'd0},      1'b0, 8'h00},
      '{'{OP_BUS,  ADDR_BUTTON0,   8'h00, 1'b0, 8'hFF, 1'b0, 18'd0},      1'b1, 8'h00},
      '{'{OP_BUS,  ADDR_BUTTON1,   8'h00, 1'b0, 8'hFF, 1'b0, 18'd0},      1'b1, 8'h00},
      '{'{OP_BUS,  16'h0000,       8'hFF, 1'b1, 8'hA5, 1'b1, 18'h3FFFF},  1'b1, 8'hA5},
      '{'{OP_BUS,  16'hFFFF,       8'h00, 1'b0, 8'h5A, 1'b0, 18'd0},      1'b1, 8'h5A},
      '{'{OP_BUS,  ADDR_READMODE,  8'h00, 1'b0, 8'h12, 1'b0, 18'd0},      1'b1, 8'h00},
      '{'{OP_LOAD, 16'h0000,       8'h3C, 1'b0, 8'h00, 1'b0, 18'd0},      1'b1, 8'h00},
      '{'{OP_LOAD, 16'h0000,       8'hC3, 1'b0, 8'h00, 1'b1, 18'h3FFFF},  1'b1, 8'h00},
      '{'{OP_BUS,  ADDR_MOTORON,   8'h00, 1'b0, 8'h01, 1'b0, 18'd0},      1'b1, 8'h01},
      '{'{OP_BUS,  ADDR_DRIVE1,    8'h00, 1'b0, 8'h02, 1'b0, 18'd0},      1'b1, 8'h02},
      '{'{OP_BUS,  ADDR_DRIVE0,    8'h00, 1'b0, 8'h03, 1'b0, 18'd0},      1'b1, 8'h03},
      '{'{OP_BUS,  ADDR_SHIFT,     8'h00, 1'b0, 8'h04, 1'b0, 18'd0},      1'b1, 8'h3C},
      '{'{OP_BUS,  ADDR_LOAD,      8'h96, 1'b1, 8'h05, 1'b0, 18'd0},      1'b1, 8'h05},
      '{'{OP_BUS,  ADDR_WRITEMODE, 8'h00, 1'b0, 8'h06, 1'b0, 18'd0},      1'b1, 8'h06},
      '{'{OP_NOP,  ADDR_KBD,       8'hFF, 1'b1, 8'hFF, 1'b1, 18'h3FFFF},  1'b1, 8'h00}
    };
    foreach (directed[i]) issue(directed[i].word, directed[i].known, directed[i].read_data);
    issue(make_word(OP_BUS, ADDR_SHIFT, 8'h00));
    issue(make_word(OP_BUS, ADDR_MOTOROFF, 8'h00));

    settings = '{2'd3, 2'd1, 2'd2, 2'd0};
    foreach (settings[s]) begin
      write_protect_set(settings[s]);
      steady = (s == 1);
      issue(make_word(OP_BUS, ADDR_DRIVE0, 8'h00), 1'b0);
      issue(make_word(OP_BUS, ADDR_READMODE, 8'h00), 1'b1, {settings[s][0], 7'd0});
      issue(make_word(OP_BUS, ADDR_DRIVE1, 8'h00), 1'b0);
      issue(make_word(OP_BUS, ADDR_READMODE, 8'h00), 1'b1, {settings[s][1], 7'd0});
      stepper_walk(s == 0 ? 160 : $urandom_range(40, 5), 1'b1);
      sent = words_sent;
      while (words_sent - sent < RANDOM_WORDS / 4) begin
        if ($urandom_range(99) < 3) stepper_walk($urandom_range(30, 2), 1'($urandom));
        else issue(random_word());
      end
      steady = 1'b0;
    end

    in_ch.valid <= 1'b0;
    wait (pending_status.size() == 0);
    repeat (SETTLE) @(posedge clk);

    $display("checked %0d status words from %0d input words, %0d of them image loads",
             words_checked, words_sent, loads_sent);
    $display("write-protect settings 0..3 exercised, deepest half-track reached %0d",
             deepest_half);
    if (!failed) begin
      $display("** io_soft_switch_disk_controller: PASSED **");
    end else begin
      $display("** io_soft_switch_disk_controller: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
design/iosd_pkg.sv
design/iosd_word_if.sv
design/iosd_in_if.sv
design/iosd_out_if.sv
design/iosd_ram.sv
design/iosd_ctrl.sv
design/iosd_datapath.sv
design/io_soft_switch_disk_controller.sv
tb/io_soft_switch_disk_controller_tb.sv
